/* rtl/bsp_pkg.sv */
// ============================================================================
// bsp_pkg
// Shared types, codes and constants for the blind stepper position controller.
// ============================================================================
package bsp_pkg;

    // Default sizes
    localparam int HISTORY_LEN_DEF = 8;
    localparam int POS_BITS_DEF    = 16;

    // Input transaction layout
    localparam int CMD_W       = 8;
    localparam int LIGHT_W     = 12;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_FIXED_W = 9;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_ADDR_W-1:0] REG_DIFF_THRESHOLD  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_THRESHOLD = 1'd1;
    localparam logic [CFG_DATA_W-1:0] DIFF_THRESHOLD_RST  = 12'd200;
    localparam logic [CFG_DATA_W-1:0] LEVEL_THRESHOLD_RST = 12'd300;

    localparam int LIMIT_RST = 1000;

    // Command bytes
    localparam logic [CMD_W-1:0] CMD_STOP  = 8'd0;
    localparam logic [CMD_W-1:0] CMD_DOWN  = 8'd1;
    localparam logic [CMD_W-1:0] CMD_UP    = 8'd2;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 8'd3;
    localparam logic [CMD_W-1:0] CMD_OPEN  = 8'd4;
    localparam logic [CMD_W-1:0] CMD_AUTO  = 8'd5;

    // Classified operations handed from front to back
    localparam logic [2:0] OP_STOP  = 3'd0;
    localparam logic [2:0] OP_DOWN  = 3'd1;
    localparam logic [2:0] OP_UP    = 3'd2;
    localparam logic [2:0] OP_CLOSE = 3'd3;
    localparam logic [2:0] OP_OPEN  = 3'd4;
    localparam logic [2:0] OP_AUTO  = 3'd5;
    localparam logic [2:0] OP_OTHER = 3'd6;
    localparam logic [2:0] OP_TICK  = 3'd7;

    // Motion and last auto move codes
    localparam logic [1:0] MOTION_STOP = 2'd0;
    localparam logic [1:0] MOTION_DOWN = 2'd1;
    localparam logic [1:0] MOTION_UP   = 2'd2;

    // Lamp bits
    localparam int LAMP_UP   = 0;
    localparam int LAMP_STOP = 1;
    localparam int LAMP_DOWN = 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [2:0] op;
        logic       light_bit;
    } item_t;

endpackage

/* rtl/bsp_front.sv */
// ============================================================================
// bsp_front
// Accepts input transactions, decodes commands and compares light samples.
// ============================================================================
module bsp_front
    import bsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  s_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output item_t                 item,
    output logic                  item_valid,
    input  logic                  item_ready
);

    logic [CFG_DATA_W-1:0] diff_thr_reg;
    logic [CFG_DATA_W-1:0] level_thr_reg;
    item_t                 item_reg;
    item_t                 item_next;
    logic                  valid_reg;
    logic [CMD_W-1:0]      command;
    logic [LIGHT_W-1:0]    light_one;
    logic [LIGHT_W-1:0]    light_two;
    logic [LIGHT_W:0]      light_diff;
    logic                  accept;

    assign command   = s_tdata[CMD_W-1:0];
    assign light_one = s_tdata[CMD_W +: LIGHT_W];
    assign light_two = s_tdata[CMD_W+LIGHT_W +: LIGHT_W];

    assign s_tready = !valid_reg || item_ready;
    assign accept   = s_tvalid && s_tready;

    // sign bit set means light_two is brighter
    assign light_diff = {1'b0, light_one} - {1'b0, light_two};

    always_comb
    begin
        item_next.light_bit = (!light_diff[LIGHT_W] && (light_diff[LIGHT_W-1:0] > diff_thr_reg))
                            || ((light_one > level_thr_reg) && (light_two > level_thr_reg));
        if (s_tuser)
        begin
            item_next.op = OP_TICK;
        end
        else
        begin
            case (command)
                CMD_STOP:  item_next.op = OP_STOP;
                CMD_DOWN:  item_next.op = OP_DOWN;
                CMD_UP:    item_next.op = OP_UP;
                CMD_CLOSE: item_next.op = OP_CLOSE;
                CMD_OPEN:  item_next.op = OP_OPEN;
                CMD_AUTO:  item_next.op = OP_AUTO;
                default:   item_next.op = OP_OTHER;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_thr_reg  <= DIFF_THRESHOLD_RST;
            level_thr_reg <= LEVEL_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_DIFF_THRESHOLD:  diff_thr_reg  <= cfg_wdata;
                REG_LEVEL_THRESHOLD: level_thr_reg <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

/* rtl/bsp_queue.sv */
// ============================================================================
// bsp_queue
// Short FIFO of classified transactions between front and back.
// ============================================================================
module bsp_queue
    import bsp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t push_item,
    input  logic  push_valid,
    output logic  push_ready,
    output item_t pop_item,
    output logic  pop_valid,
    input  logic  pop_ready
);

    item_t             store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = store_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/bsp_back.sv */
// ============================================================================
// bsp_back
// Executes classified transactions: motion, calibration, auto mode, lamps.
// ============================================================================
module bsp_back
    import bsp_pkg::*;
#(
    parameter int HISTORY_LEN = HISTORY_LEN_DEF,
    parameter int POS_BITS    = POS_BITS_DEF
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  item_t                                       pop_item,
    input  logic                                        pop_valid,
    output logic                                        pop_ready,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [((OUT_FIXED_W+2*POS_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int OUT_W = ((OUT_FIXED_W + 2*POS_BITS + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - (OUT_FIXED_W + 2*POS_BITS);
    localparam logic [POS_BITS-1:0] LIMIT_RST_P = POS_BITS'(LIMIT_RST);

    logic [POS_BITS-1:0]    pos_reg,    pos_next;
    logic [3:0]             pos_mod_reg, pos_mod_next;   // position modulo ten
    logic [POS_BITS-1:0]    limit_reg,  limit_next;
    logic [1:0]             motion_reg, motion_next;
    logic                   cal_open_reg, cal_open_next;
    logic                   cal_close_reg, cal_close_next;
    logic                   auto_reg,   auto_next;
    logic [1:0]             last_move_reg, last_move_next;
    logic [HISTORY_LEN-1:0] hist_reg,   hist_next;
    logic [2:0]             lamps_reg,  lamps_next;
    logic                   dir_up_reg, dir_up_next;
    logic                   awake_reg,  awake_next;
    logic                   pulse, prep, lrep;
    logic                   fire;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;
    logic [OUT_W-1:0]       out_data_next;
    logic [3:0]             mod_inc, mod_dec;

    assign pop_ready = !out_valid_reg || m_tready;
    assign fire      = pop_valid && pop_ready;

    assign mod_inc = (pos_mod_reg == 4'd9) ? 4'd0 : pos_mod_reg + 4'd1;
    assign mod_dec = (pos_mod_reg == 4'd0) ? 4'd9 : pos_mod_reg - 4'd1;

    always_comb
    begin
        pos_next       = pos_reg;
        pos_mod_next   = pos_mod_reg;
        limit_next     = limit_reg;
        motion_next    = motion_reg;
        cal_open_next  = cal_open_reg;
        cal_close_next = cal_close_reg;
        auto_next      = auto_reg;
        last_move_next = last_move_reg;
        hist_next      = hist_reg;
        lamps_next     = lamps_reg;
        dir_up_next    = dir_up_reg;
        awake_next     = awake_reg;
        pulse          = 1'b0;
        prep           = 1'b0;
        lrep           = 1'b0;

        if (pop_item.op == OP_TICK)
        begin
            if (auto_reg)
            begin
                hist_next = {hist_reg[HISTORY_LEN-2:0], pop_item.light_bit};
                if (hist_next == '1)
                begin
                    if (last_move_reg != MOTION_UP)
                    begin
                        last_move_next = MOTION_UP;
                        motion_next    = MOTION_UP;
                    end
                end
                else if (hist_next == '0)
                begin
                    if (last_move_reg != MOTION_DOWN)
                    begin
                        last_move_next = MOTION_DOWN;
                        motion_next    = MOTION_DOWN;
                    end
                end
            end

            if (motion_next == MOTION_UP)
            begin
                dir_up_next = 1'b1;
                if (cal_open_reg || cal_close_reg)
                begin
                    pulse = 1'b1;
                end
                else if (pos_reg != '0)
                begin
                    pos_next     = pos_reg - 1'b1;
                    pos_mod_next = mod_dec;
                    pulse        = 1'b1;
                    prep         = (mod_dec == 4'd0);
                end
                else
                begin
                    motion_next = MOTION_STOP;
                end
            end
            else if (motion_next == MOTION_DOWN)
            begin
                dir_up_next = 1'b0;
                if (cal_open_reg || cal_close_reg)
                begin
                    // saturating count while calibrating
                    if (pos_reg != '1)
                    begin
                        pos_next     = pos_reg + 1'b1;
                        pos_mod_next = mod_inc;
                    end
                    pulse = 1'b1;
                end
                else if (pos_reg < limit_reg)
                begin
                    pos_next     = pos_reg + 1'b1;
                    pos_mod_next = mod_inc;
                    pulse        = 1'b1;
                    prep         = (mod_inc == 4'd0);
                end
                else
                begin
                    motion_next = MOTION_STOP;
                end
            end
            awake_next = pulse;
        end
        else
        begin
            motion_next = MOTION_STOP;
            case (pop_item.op)
                OP_STOP:
                begin
                    prep       = (pos_mod_reg == 4'd0);
                    lamps_next = 3'b000;
                    lamps_next[LAMP_STOP] = 1'b1;
                end
                OP_DOWN:
                begin
                    lamps_next[LAMP_DOWN] = 1'b1;
                    lamps_next[LAMP_STOP] = 1'b0;
                    motion_next = MOTION_DOWN;
                end
                OP_UP:
                begin
                    lamps_next[LAMP_UP]   = 1'b1;
                    lamps_next[LAMP_STOP] = 1'b0;
                    motion_next = MOTION_UP;
                end
                OP_CLOSE:
                begin
                    if (cal_close_reg)
                    begin
                        pos_next       = '0;
                        pos_mod_next   = 4'd0;
                        cal_close_next = 1'b0;
                    end
                    else
                    begin
                        cal_close_next = 1'b1;
                    end
                end
                OP_OPEN:
                begin
                    if (cal_open_reg)
                    begin
                        limit_next    = pos_reg;
                        lrep          = 1'b1;
                        cal_open_next = 1'b0;
                    end
                    else
                    begin
                        cal_open_next = 1'b1;
                    end
                end
                OP_AUTO:
                begin
                    auto_next      = !auto_reg;
                    last_move_next = MOTION_STOP;
                end
                default: ;
            endcase
        end
    end

    // tdata, highest bit first (step pulse lands in bit 0)
    always_comb
    begin
        out_data_next = {{PAD_W{1'b0}},
                         auto_next,
                         lamps_next[LAMP_DOWN],
                         lamps_next[LAMP_STOP],
                         lamps_next[LAMP_UP],
                         limit_next,
                         lrep,
                         prep,
                         pos_next,
                         awake_next,
                         dir_up_next,
                         pulse};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            pos_mod_reg   <= 4'd0;
            limit_reg     <= LIMIT_RST_P;
            motion_reg    <= MOTION_STOP;
            cal_open_reg  <= 1'b0;
            cal_close_reg <= 1'b0;
            auto_reg      <= 1'b0;
            last_move_reg <= MOTION_STOP;
            hist_reg      <= '0;
            lamps_reg     <= 3'b000;
            dir_up_reg    <= 1'b1;
            awake_reg     <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg       <= pos_next;
            pos_mod_reg   <= pos_mod_next;
            limit_reg     <= limit_next;
            motion_reg    <= motion_next;
            cal_open_reg  <= cal_open_next;
            cal_close_reg <= cal_close_next;
            auto_reg      <= auto_next;
            last_move_reg <= last_move_next;
            hist_reg      <= hist_next;
            lamps_reg     <= lamps_next;
            dir_up_reg    <= dir_up_next;
            awake_reg     <= awake_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/blind_stepper_position_controller.sv */
// ============================================================================
// blind_stepper_position_controller
// Roller-blind stepper control: commands, motion ticks, calibration, auto mode.
// ============================================================================
// Usage:
//   Slave stream (s_*): one transaction per command byte or motion tick.
//   s_tuser is the mode flag (0 command, 1 tick); s_tdata carries the command
//   byte and two 12-bit light samples. Every input transaction yields exactly
//   one result transaction on the master stream (m_*), in order.
//   cfg_we/cfg_addr/cfg_wdata write the two light thresholds (index 0 diff,
//   index 1 level); write them only while no transaction is in flight.
// Path: a result passes through the front register, the two-entry queue and
//   the output register before it shows on m_tvalid.
// Throughput: one transaction per cycle while m_tready stays high; all per-item
//   state update is computed combinationally in the back stage, so nothing iterates.
// Reset: rst_n resets all control state at once; position 0, travel limit 1000
//   (truncated to POS_BITS), motion stopped, auto off, lamps off, direction up.
// Stall: while m_tready is low the result waits in the output register; the
//   queue and front register keep absorbing input, and s_tready falls only
//   once both are full. No transaction is dropped or repeated.
// ============================================================================
module blind_stepper_position_controller
    import bsp_pkg::*;
#(
    parameter int HISTORY_LEN = HISTORY_LEN_DEF,
    parameter int POS_BITS    = POS_BITS_DEF
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    // slave stream
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // [7:0] command, [19:8] light_one, [31:20] light_two
    input  logic [IN_TDATA_W-1:0]                       s_tdata,
    // [0] mode
    input  logic                                        s_tuser,
    // master stream
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // step_pulse, direction_up, motor_awake, position, position_report,
    // limit_report, travel_limit, up lamp, stop lamp, down lamp, auto_on,
    // then zero fill (lowest bit first)
    output logic [((OUT_FIXED_W+2*POS_BITS+7)/8)*8-1:0] m_tdata,
    // configuration
    input  logic                                        cfg_we,
    input  logic [CFG_ADDR_W-1:0]                       cfg_addr,
    input  logic [CFG_DATA_W-1:0]                       cfg_wdata
);

    item_t front_item;
    logic  front_valid;
    logic  front_ready;
    item_t queue_item;
    logic  queue_valid;
    logic  queue_ready;

    // front: accept, decode command, compare light samples
    bsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    // decoupling queue
    bsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_item   (queue_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    // back: state update and result register
    bsp_back #(
        .HISTORY_LEN (HISTORY_LEN),
        .POS_BITS    (POS_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_item  (queue_item),
        .pop_valid (queue_valid),
        .pop_ready (queue_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* tb/blind_stepper_position_controller_tb.sv */
// ============================================================================
// blind_stepper_position_controller_tb
// Self-checking stream testbench for the roller-blind stepper controller.
// ============================================================================
// A queue of pending input transactions feeds a clocked driver. An in-bench
// copy of the controller state predicts one result per accepted transaction.
// A clocked monitor checks each result field by field against the oldest
// prediction. The run covers a directed opener and randomized phases. These
// phases vary the thresholds, sender gaps and receiver stalls, and include
// one long receiver hold-off.
// ============================================================================
module blind_stepper_position_controller_tb;
    import bsp_pkg::*;

    localparam int OUT_W       = ((OUT_FIXED_W + 2*POS_BITS_DEF + 7)/8)*8;
    localparam int PAD_W       = OUT_W - OUT_FIXED_W - 2*POS_BITS_DEF;
    localparam int QUIET_LIMIT = 4000;   // cycles with no transaction on either side
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int SETTLE      = 4;      // output latency plus margin

    localparam logic MODE_CMD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [CMD_W-1:0]         command;
        logic [LIGHT_W-1:0]       light_one;
        logic [LIGHT_W-1:0]       light_two;
    } blind_item_t;

    // result layout, msb first so that step_pulse lands in bit 0
    typedef struct packed {
        logic [PAD_W-1:0]         fill;
        logic                     auto_on;
        logic                     led_lower;
        logic                     led_halt;
        logic                     led_up;
        logic [POS_BITS_DEF-1:0]  travel_limit;
        logic                     limit_report;
        logic                     position_report;
        logic [POS_BITS_DEF-1:0]  position;
        logic                     motor_awake;
        logic                     direction_up;
        logic                     step_pulse;
    } blind_result_t;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata   = '0;   // [7:0] command, [19:8] light_one, [31:20] light_two
    logic                  s_tuser   = 1'b0; // [0] mode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;          // step_pulse .. auto_on, zero fill on top
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    blind_stepper_position_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Controller state mirror (post-reset values)
    // ------------------------------------------------------------------------
    logic [CFG_DATA_W-1:0]      diff_thr    = DIFF_THRESHOLD_RST;
    logic [CFG_DATA_W-1:0]      level_thr   = LEVEL_THRESHOLD_RST;
    logic [POS_BITS_DEF-1:0]    blind_pos   = '0;
    logic [POS_BITS_DEF-1:0]    blind_limit = POS_BITS_DEF'(LIMIT_RST);
    logic [1:0]                 blind_motion    = MOTION_STOP;
    logic [1:0]                 auto_last       = MOTION_STOP;
    logic                       cal_open    = 1'b0;
    logic                       cal_close   = 1'b0;
    logic                       auto_en     = 1'b0;
    logic [HISTORY_LEN_DEF-1:0] light_hist  = '0;
    logic [2:0]                 lamps       = '0;
    logic                       dir_up      = 1'b1;
    logic                       awake       = 1'b0;

    blind_item_t   blind_pending[$];    // items waiting for the driver
    blind_result_t blind_expected[$];   // predicted results in flight
    int            n_queued  = 0;
    int            n_errors  = 0;
    int unsigned   tx_idle_pct  = 0;
    int unsigned   rx_stall_pct = 0;
    logic          hold_arm  = 1'b0;

    // Advance the mirror by one accepted transaction and return its result.
    function automatic blind_result_t step_blind(input blind_item_t it);
        blind_result_t r;
        logic          hbit;
        logic [1:0]    next_motion;
        r = '0;
        if (it.mode == MODE_TICK) begin
            if (auto_en) begin
                // difference above diff threshold, or both lights above level
                hbit = (int'(it.light_one) - int'(it.light_two) > int'(diff_thr)) ||
                       (it.light_one > level_thr && it.light_two > level_thr);
                light_hist = {light_hist[HISTORY_LEN_DEF-2:0], hbit};
                if (light_hist == '1) begin
                    if (auto_last != MOTION_UP) begin
                        auto_last    = MOTION_UP;
                        blind_motion = MOTION_UP;
                    end
                end else if (light_hist == '0) begin
                    if (auto_last != MOTION_DOWN) begin
                        auto_last    = MOTION_DOWN;
                        blind_motion = MOTION_DOWN;
                    end
                end
            end
            if (blind_motion == MOTION_UP) begin
                dir_up = 1'b1;
                if (cal_open || cal_close)
                    r.step_pulse = 1'b1;           // pulses, position held
                else if (blind_pos != '0) begin
                    blind_pos         = blind_pos - 1'b1;
                    r.step_pulse      = 1'b1;
                    r.position_report = (blind_pos % 10) == 0;
                end else
                    blind_motion = MOTION_STOP;
            end else if (blind_motion == MOTION_DOWN) begin
                dir_up = 1'b0;
                if (cal_open || cal_close) begin
                    if (blind_pos != '1)           // limit ignored, saturates
                        blind_pos = blind_pos + 1'b1;
                    r.step_pulse = 1'b1;
                end else if (blind_pos < blind_limit) begin
                    blind_pos         = blind_pos + 1'b1;
                    r.step_pulse      = 1'b1;
                    r.position_report = (blind_pos % 10) == 0;
                end else
                    blind_motion = MOTION_STOP;
            end
            awake = r.step_pulse;
        end else begin
            next_motion = MOTION_STOP;
            case (it.command)
                CMD_STOP: begin
                    r.position_report = (blind_pos % 10) == 0;
                    lamps             = '0;
                    lamps[LAMP_STOP]  = 1'b1;
                end
                CMD_DOWN: begin
                    lamps[LAMP_DOWN] = 1'b1;
                    lamps[LAMP_STOP] = 1'b0;
                    next_motion      = MOTION_DOWN;
                end
                CMD_UP: begin
                    lamps[LAMP_UP]   = 1'b1;
                    lamps[LAMP_STOP] = 1'b0;
                    next_motion      = MOTION_UP;
                end
                CMD_CLOSE: begin
                    if (cal_close) begin
                        blind_pos = '0;
                        cal_close = 1'b0;
                    end else
                        cal_close = 1'b1;
                end
                CMD_OPEN: begin
                    if (cal_open) begin
                        blind_limit    = blind_pos;
                        r.limit_report = 1'b1;
                        cal_open       = 1'b0;
                    end else
                        cal_open = 1'b1;
                end
                CMD_AUTO: begin
                    auto_en   = ~auto_en;
                    auto_last = MOTION_STOP;
                end
                default: ;                         // unknown byte: silent stop
            endcase
            blind_motion = next_motion;
        end
        r.direction_up = dir_up;
        r.motor_awake  = awake;
        r.position     = blind_pos;
        r.travel_limit = blind_limit;
        r.led_up       = lamps[LAMP_UP];
        r.led_halt     = lamps[LAMP_STOP];
        r.led_lower    = lamps[LAMP_DOWN];
        r.auto_on      = auto_en;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents pending items, predicts on each accepted transaction
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : drive_blk
        blind_item_t acc;
        blind_item_t nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= MODE_CMD;
        end else begin
            if (s_tvalid && s_tready) begin
                acc.mode      = s_tuser;
                acc.command   = s_tdata[CMD_W-1:0];
                acc.light_one = s_tdata[CMD_W +: LIGHT_W];
                acc.light_two = s_tdata[CMD_W+LIGHT_W +: LIGHT_W];
                blind_expected.push_back(step_blind(acc));
            end
            // a held transaction stays put until accepted
            if (!s_tvalid || s_tready) begin
                if (blind_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt      = blind_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.mode;
                    s_tdata  <= {nxt.light_two, nxt.light_one, nxt.command};
                end else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks results, drives m_tready (random stall or long hold)
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor_blk
        blind_result_t got;
        blind_result_t want;
        int            hold_left;
        bit            hold_used;
        if (!rst_n) begin
            m_tready  <= 1'b0;
            hold_left = 0;
            hold_used = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = blind_result_t'(m_tdata);
                if (blind_expected.size() == 0) begin
                    $error("result transaction with nothing expected");
                    n_errors++;
                end else begin
                    want = blind_expected.pop_front();
                    check_field("step_pulse",      want.step_pulse,      got.step_pulse);
                    check_field("direction_up",    want.direction_up,    got.direction_up);
                    check_field("motor_awake",     want.motor_awake,     got.motor_awake);
                    check_field("position",        want.position,        got.position);
                    check_field("position_report", want.position_report, got.position_report);
                    check_field("limit_report",    want.limit_report,    got.limit_report);
                    check_field("travel_limit",    want.travel_limit,    got.travel_limit);
                    check_field("led_up",          want.led_up,          got.led_up);
                    check_field("led_halt",        want.led_halt,        got.led_halt);
                    check_field("led_lower",       want.led_lower,       got.led_lower);
                    check_field("auto_on",         want.auto_on,         got.auto_on);
                    check_field("fill",            want.fill,            got.fill);
                end
            end
            // one-shot hold-off: sender keeps going so the block backs up
            if (hold_arm && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: no transaction on either side for too long
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [LIGHT_W-1:0] rand_light();
        return LIGHT_W'($urandom_range(4095));
    endfunction

    task automatic push_cmd(input logic [CMD_W-1:0] c);
        blind_item_t it;
        it.mode      = MODE_CMD;
        it.command   = c;
        it.light_one = rand_light();          // ignored on commands
        it.light_two = rand_light();
        blind_pending.push_back(it);
        n_queued++;
    endtask

    task automatic push_tick(input logic [LIGHT_W-1:0] l1, input logic [LIGHT_W-1:0] l2);
        blind_item_t it;
        it.mode      = MODE_TICK;
        it.command   = CMD_W'($urandom_range(255));    // ignored on ticks
        it.light_one = l1;
        it.light_two = l2;
        blind_pending.push_back(it);
        n_queued++;
    endtask

    // wait at the falling edge so all driver/monitor updates have settled
    task automatic drain_blind();
        do @(negedge clk);
        while (blind_pending.size() != 0 || s_tvalid || blind_expected.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [CFG_ADDR_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == REG_DIFF_THRESHOLD)
            diff_thr = val;
        else
            level_thr = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // block is idle here; reprogram thresholds and pick the flow-control mix
    task automatic start_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                               input logic [CFG_DATA_W-1:0] d,
                               input logic [CFG_DATA_W-1:0] l);
        drain_blind();
        write_threshold(REG_DIFF_THRESHOLD, d);
        write_threshold(REG_LEVEL_THRESHOLD, l);
        @(posedge clk);
        tx_idle_pct  <= tx_pct;
        rx_stall_pct <= rx_pct;
        @(posedge clk);
    endtask

    // Mostly well-formed sequences: moves, limit calibration, zeroing,
    // auto runs with bright/dark stretches; the rest is noise.
    task automatic queue_random_traffic(input int n_items);
        int goal;
        int kind;
        int runs;
        int sel;
        bit bright;
        logic [LIGHT_W-1:0] l1;
        logic [LIGHT_W-1:0] l2;
        goal = n_queued + n_items;
        while (n_queued < goal) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                push_cmd($urandom_range(1) ? CMD_UP : CMD_DOWN);
                repeat ($urandom_range(40, 1))
                    push_tick(rand_light(), rand_light());
                if ($urandom_range(1))
                    push_cmd(CMD_STOP);
            end else if (kind < 42) begin
                // new travel limit a little past the current position
                push_cmd(CMD_OPEN);
                push_cmd(CMD_DOWN);
                repeat ($urandom_range(60))
                    push_tick(rand_light(), rand_light());
                push_cmd(CMD_OPEN);
            end else if (kind < 52) begin
                push_cmd(CMD_CLOSE);
                push_cmd($urandom_range(1) ? CMD_UP : CMD_DOWN);
                repeat ($urandom_range(15))
                    push_tick(rand_light(), rand_light());
                push_cmd(CMD_CLOSE);
            end else if (kind < 80) begin
                push_cmd(CMD_AUTO);
                runs = $urandom_range(5, 1);
                repeat (runs) begin
                    bright = 1'($urandom_range(1));
                    repeat ($urandom_range(12, 1)) begin
                        sel = $urandom_range(9);
                        if (sel == 0) begin
                            l1 = rand_light();
                            l2 = rand_light();
                        end else if (bright) begin
                            l1 = LIGHT_W'($urandom_range(4095, 3900));
                            l2 = rand_light();
                        end else begin
                            l1 = LIGHT_W'($urandom_range(150));
                            l2 = LIGHT_W'($urandom_range(4095, l1));
                        end
                        push_tick(l1, l2);
                    end
                    if ($urandom_range(7) == 0)
                        push_cmd($urandom_range(1) ? CMD_STOP : CMD_UP);
                end
                if ($urandom_range(5) != 0)
                    push_cmd(CMD_AUTO);
            end else begin
                if ($urandom_range(1))
                    push_cmd(CMD_W'($urandom_range(255)));
                else
                    push_tick(rand_light(), rand_light());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opener, reset thresholds, no idling
        push_cmd(CMD_STOP);                   // stop report at position zero
        push_tick(12'd0, 12'd0);              // tick while stopped
        push_cmd(CMD_DOWN);
        repeat (3) push_tick(12'hFFF, 12'h000);
        push_cmd(CMD_STOP);                   // position 3, no report
        push_cmd(CMD_UP);
        repeat (4) push_tick(12'h000, 12'hFFF);  // last one hits the zero bound
        push_cmd(8'hFF);                      // unknown command bytes
        push_cmd(CMD_AUTO + 8'd1);
        push_cmd(CMD_CLOSE);
        push_cmd(CMD_UP);
        push_tick(12'h800, 12'h7FF);          // calibrating up: pulse only
        push_cmd(CMD_DOWN);
        push_tick(12'h7FF, 12'h800);          // calibrating down: counts up
        push_cmd(CMD_CLOSE);                  // zeroes position
        push_cmd(CMD_OPEN);
        push_cmd(CMD_OPEN);                   // limit becomes 0, reported
        push_cmd(CMD_DOWN);
        push_tick(12'hFFF, 12'hFFF);          // limit bound reached
        push_cmd(CMD_AUTO);
        push_tick(12'hFFF, 12'h000);
        push_tick(12'h000, 12'hFFF);
        push_tick(12'hFFF, 12'hFFF);
        push_tick(12'h000, 12'h000);
        push_cmd(CMD_AUTO);
        drain_blind();

        start_phase(0, 0, '0, '0);
        queue_random_traffic(200);

        start_phase(57, 0, '1, '1);
        queue_random_traffic(200);

        start_phase(0, 57, CFG_DATA_W'($urandom_range(4095)),
                    CFG_DATA_W'($urandom_range(4095)));
        queue_random_traffic(200);

        start_phase(18, 18, DIFF_THRESHOLD_RST, LEVEL_THRESHOLD_RST);
        queue_random_traffic(200);

        // receiver holds off while the sender keeps offering transactions
        start_phase(0, 0, 12'd100, 12'd2000);
        hold_arm <= 1'b1;
        queue_random_traffic(100);

        start_phase(18, 18, '1, '0);
        queue_random_traffic(150);

        drain_blind();
        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
